FILE: src/vcpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// van Cittert pixel update package
// Shared constants, register indexes and pipeline latencies.
// ----------------------------------------------------------------------------
package vcpu_pkg;

    localparam int DIV_LAT = 16;
    localparam int SIN_LAT = 4;
    localparam int LOG_LAT = 17;
    localparam int POW_LAT = 5;
    localparam int WGT_LAT = DIV_LAT + SIN_LAT + LOG_LAT + POW_LAT;

    localparam logic [16:0] SIN_A   = 17'd102944;
    localparam logic [15:0] SIN_B   = 16'd42047;
    localparam logic [15:0] SIN_C   = 16'd4640;
    localparam logic [15:0] EXP_C1  = 16'd45591;
    localparam logic [15:0] EXP_C2  = 16'd14824;
    localparam logic [15:0] EXP_C3  = 16'd5121;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [2:0] {
        REG_RELAX_MODE   = 3'd0,
        REG_RELAX_GAIN   = 3'd1,
        REG_CLAMP_ENABLE = 3'd2,
        REG_RANGE_LOW    = 3'd3,
        REG_RANGE_HIGH   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] res;
        logic signed [31:0] est;
        logic               le_lo;
        logic               ge_hi;
    } side_t;

endpackage
`default_nettype wire

FILE: src/vcpu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces a 16-bit quotient of (num << 16) / den, one bit per stage.
// ----------------------------------------------------------------------------
module vcpu_div (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [15:0] quo
);
    import vcpu_pkg::*;

    logic [31:0] rem_reg [1:DIV_LAT];
    logic [31:0] den_reg [1:DIV_LAT];
    logic [15:0] q_reg   [1:DIV_LAT];

    genvar i;
    generate
        for (i = 0; i < DIV_LAT; i++) begin : g_step
            logic [31:0] rem_in;
            logic [31:0] den_in;
            logic [15:0] q_in;
            logic [32:0] shifted;
            logic        ge;
            logic [32:0] diff;
            if (i == 0) begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign q_in   = 16'd0;
            end else begin : g_rest
                assign rem_in = rem_reg[i];
                assign den_in = den_reg[i];
                assign q_in   = q_reg[i];
            end
            assign shifted = {rem_in, 1'b0};
            assign ge      = shifted >= {1'b0, den_in};
            assign diff    = shifted - {1'b0, den_in};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? diff[31:0] : shifted[31:0];
                    den_reg[i+1] <= den_in;
                    q_reg[i+1]   <= {q_in[14:0], ge};
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_LAT];

endmodule
`default_nettype wire

FILE: src/vcpu_sine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sine polynomial pipeline
// Evaluates sin(pi/2 * x) in Q16 with truncating products, capped at 1.0.
// ----------------------------------------------------------------------------
module vcpu_sine (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] x,
    output logic [16:0] s
);
    import vcpu_pkg::*;

    logic [15:0] x1_reg, x2_reg, x3_reg;
    logic [15:0] sq1_reg, sq2_reg;
    logic [15:0] t1_reg;
    logic [16:0] t2_reg;
    logic [16:0] s_reg;

    logic [31:0] sq_prod;
    logic [31:0] c_prod;
    logic [31:0] b_prod;
    logic [32:0] a_prod;

    assign sq_prod = x * x;
    assign c_prod  = {16'd0, SIN_C} * {16'd0, sq1_reg};
    assign b_prod  = {16'd0, t1_reg} * {16'd0, sq2_reg};
    assign a_prod  = {16'd0, t2_reg} * {17'd0, x3_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x;
            sq1_reg <= sq_prod[31:16];
            x2_reg  <= x1_reg;
            sq2_reg <= sq1_reg;
            t1_reg  <= SIN_B - c_prod[31:16];
            x3_reg  <= x2_reg;
            t2_reg  <= SIN_A - {1'b0, b_prod[31:16]};
            s_reg   <= (a_prod[32:16] > ONE_Q16) ? ONE_Q16 : a_prod[32:16];
        end
    end

    assign s = s_reg;

endmodule
`default_nettype wire

FILE: src/vcpu_log2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Negative base-2 logarithm pipeline
// Normalizes the sine value and extracts 16 fraction bits by squaring.
// ----------------------------------------------------------------------------
module vcpu_log2 (
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] s,
    output logic [20:0] neg_log,
    output logic        s_zero
);
    import vcpu_pkg::*;

    localparam int SQ_STEPS = LOG_LAT - 1;

    logic [4:0]  p_reg    [0:SQ_STEPS];
    logic [30:0] x_reg    [0:SQ_STEPS];
    logic [15:0] frac_reg [0:SQ_STEPS];
    logic        zero_reg [0:SQ_STEPS];

    logic [4:0]  lead;
    logic [47:0] norm;

    always_comb
    begin
        lead = 5'd0;
        for (int k = 1; k <= 16; k++)
        begin
            if (s[k])
            begin
                lead = 5'(k);
            end
        end
    end

    assign norm = {31'd0, s} << (5'd30 - lead);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]    <= lead;
            x_reg[0]    <= norm[30:0];
            frac_reg[0] <= 16'd0;
            zero_reg[0] <= (s == 17'd0);
        end
    end

    genvar i;
    generate
        for (i = 0; i < SQ_STEPS; i++) begin : g_sq
            logic [61:0] sq;
            logic [31:0] y;
            assign sq = x_reg[i] * x_reg[i];
            assign y  = sq[61:30];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_reg[i+1]    <= p_reg[i];
                    zero_reg[i+1] <= zero_reg[i];
                    x_reg[i+1]    <= y[31] ? y[31:1] : y[30:0];
                    frac_reg[i+1] <= frac_reg[i] | ({15'd0, y[31]} << (SQ_STEPS - 1 - i));
                end
            end
        end
    endgenerate

    assign neg_log = {5'd16 - p_reg[SQ_STEPS], 16'd0} - {5'd0, frac_reg[SQ_STEPS]};
    assign s_zero  = zero_reg[SQ_STEPS];

endmodule
`default_nettype wire

FILE: src/vcpu_pow.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Power pipeline
// Scales the logarithm by the gain and raises two to the negative result.
// ----------------------------------------------------------------------------
module vcpu_pow (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] gain,
    input  logic [20:0] neg_log,
    input  logic        zero_in,
    output logic [16:0] w,
    output logic        zero_out
);
    import vcpu_pkg::*;

    logic [24:0] t_reg;
    logic [9:0]  e2_reg, e3_reg, e4_reg;
    logic [15:0] f2_reg, f3_reg;
    logic        fz2_reg, fz3_reg;
    logic [15:0] h1_reg, h2_reg;
    logic [16:0] m_reg;
    logic [16:0] w_reg;
    logic        z1_reg, z2_reg, z3_reg, z4_reg, z5_reg;

    logic [36:0] gl_prod;
    logic [8:0]  ip;
    logic [15:0] fp;
    logic        fz;
    logic [16:0] f_full;
    logic [31:0] p1, p2, p3;
    logic [16:0] shifted;

    assign gl_prod = {21'd0, gain} * {16'd0, neg_log};
    assign ip      = t_reg[24:16];
    assign fp      = t_reg[15:0];
    assign fz      = (fp == 16'd0);
    assign f_full  = ONE_Q16 - {1'b0, fp};
    assign p1      = {16'd0, EXP_C3} * {16'd0, f_full[15:0]};
    assign p2      = {16'd0, EXP_C2 + h1_reg} * {16'd0, f2_reg};
    assign p3      = {16'd0, EXP_C1 + h2_reg} * {16'd0, f3_reg};
    assign shifted = m_reg >> e4_reg[4:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= gl_prod[36:12];
            z1_reg  <= zero_in;

            e2_reg  <= fz ? {1'b0, ip} : {1'b0, ip} + 10'd1;
            f2_reg  <= f_full[15:0];
            fz2_reg <= fz;
            h1_reg  <= p1[31:16];
            z2_reg  <= z1_reg;

            e3_reg  <= e2_reg;
            f3_reg  <= f2_reg;
            fz3_reg <= fz2_reg;
            h2_reg  <= p2[31:16];
            z3_reg  <= z2_reg;

            e4_reg  <= e3_reg;
            m_reg   <= fz3_reg ? ONE_Q16 : ONE_Q16 + {1'b0, p3[31:16]};
            z4_reg  <= z3_reg;

            if (e4_reg >= 10'd32)
            begin
                w_reg <= 17'd0;
            end
            else
            begin
                w_reg <= (shifted > ONE_Q16) ? ONE_Q16 : shifted;
            end
            z5_reg  <= z4_reg;
        end
    end

    assign w        = w_reg;
    assign zero_out = z5_reg;

endmodule
`default_nettype wire

FILE: src/van_cittert_pixel_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// van Cittert pixel update
// Residual, relaxation weight and estimate update for one pixel per cycle when not stalled.
// ----------------------------------------------------------------------------
// The block accepts one pixel transaction in every cycle in which in_stall is
// low; the latency is set by the sine weight path, which holds a 16-stage
// divider, a 4-stage sine polynomial, a 17-stage logarithm and a 5-stage power
// unit, plus input, multiply and output registers. All stages advance together
// while the output register is empty or taken, so a stall on the output side
// reaches the input in the same cycle. Configuration registers must be written
// only while no transaction is in flight; the block does not enforce this.
module van_cittert_pixel_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  observed_pixel,
    input  logic signed [31:0]  reblurred_pixel,
    input  logic signed [31:0]  estimate_pixel,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  new_estimate,
    output logic signed [31:0]  residual
);
    import vcpu_pkg::*;

    logic               relax_mode_reg;
    logic [15:0]        relax_gain_reg;
    logic               clamp_enable_reg;
    logic signed [31:0] range_low_reg;
    logic signed [31:0] range_high_reg;

    logic               en;
    side_t              side_reg [0:WGT_LAT];
    logic               vld_reg  [0:WGT_LAT];
    logic [32:0]        diff_reg;
    logic [32:0]        den_reg;

    logic signed [32:0] res_wide;
    logic signed [31:0] res_sat;
    logic [15:0]        quo;
    logic [16:0]        sine_s;
    logic [20:0]        neg_log;
    logic               log_zero;
    logic [16:0]        pow_w;
    logic               pow_zero;
    logic [16:0]        w_sel;
    logic [16:0]        mult;
    logic signed [49:0] prod;
    logic signed [37:0] corr;

    logic signed [37:0] corr_reg;
    logic signed [31:0] est_m_reg;
    logic signed [31:0] res_m_reg;
    logic               vld_m_reg;

    logic signed [38:0] sum;
    logic signed [38:0] clamped;
    logic signed [31:0] new_est_next;
    logic signed [31:0] new_est_reg;
    logic signed [31:0] residual_reg;
    logic               out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_mode_reg   <= 1'b0;
            relax_gain_reg   <= 16'd4096;
            clamp_enable_reg <= 1'b0;
            range_low_reg    <= 32'sd0;
            range_high_reg   <= 32'sd268435456;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RELAX_MODE:   relax_mode_reg   <= cfg_data[0];
                REG_RELAX_GAIN:   relax_gain_reg   <= cfg_data[15:0];
                REG_CLAMP_ENABLE: clamp_enable_reg <= cfg_data[0];
                REG_RANGE_LOW:    range_low_reg    <= cfg_data;
                REG_RANGE_HIGH:   range_high_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    assign res_wide = {observed_pixel[31], observed_pixel}
                    - {reblurred_pixel[31], reblurred_pixel};
    always_comb
    begin
        if (res_wide > 33'sh07FFFFFFF)
        begin
            res_sat = 32'sh7FFFFFFF;
        end
        else if (res_wide < -33'sh080000000)
        begin
            res_sat = 32'sh80000000;
        end
        else
        begin
            res_sat = res_wide[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= WGT_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            vld_m_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < WGT_LAT; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
            vld_m_reg     <= vld_reg[WGT_LAT];
            out_valid_reg <= vld_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].res   <= res_sat;
            side_reg[0].est   <= estimate_pixel;
            side_reg[0].le_lo <= estimate_pixel <= range_low_reg;
            side_reg[0].ge_hi <= estimate_pixel >= range_high_reg;
            diff_reg <= {estimate_pixel[31], estimate_pixel}
                      - {range_low_reg[31], range_low_reg};
            den_reg  <= {range_high_reg[31], range_high_reg}
                      - {range_low_reg[31], range_low_reg};
            for (int k = 0; k < WGT_LAT; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    vcpu_div u_div (
        .clk (clk),
        .en  (en),
        .num (diff_reg[31:0]),
        .den (den_reg[31:0]),
        .quo (quo)
    );

    vcpu_sine u_sine (
        .clk (clk),
        .en  (en),
        .x   (quo),
        .s   (sine_s)
    );

    vcpu_log2 u_log2 (
        .clk     (clk),
        .en      (en),
        .s       (sine_s),
        .neg_log (neg_log),
        .s_zero  (log_zero)
    );

    vcpu_pow u_pow (
        .clk      (clk),
        .en       (en),
        .gain     (relax_gain_reg),
        .neg_log  (neg_log),
        .zero_in  (log_zero),
        .w        (pow_w),
        .zero_out (pow_zero)
    );

    always_comb
    begin
        if (side_reg[WGT_LAT].le_lo)
        begin
            w_sel = 17'd0;
        end
        else if (side_reg[WGT_LAT].ge_hi || relax_gain_reg == 16'd0)
        begin
            w_sel = ONE_Q16;
        end
        else if (pow_zero)
        begin
            w_sel = 17'd0;
        end
        else
        begin
            w_sel = pow_w;
        end
    end

    assign mult = relax_mode_reg ? w_sel : {1'b0, relax_gain_reg};
    assign prod = side_reg[WGT_LAT].res * $signed({1'b0, mult});
    assign corr = relax_mode_reg ? 38'(prod >>> 16) : 38'(prod >>> 12);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            corr_reg  <= corr;
            est_m_reg <= side_reg[WGT_LAT].est;
            res_m_reg <= side_reg[WGT_LAT].res;
        end
    end

    assign sum = 39'(est_m_reg) + 39'(corr_reg);

    always_comb
    begin
        clamped = sum;
        if (clamp_enable_reg)
        begin
            if (clamped < 39'(range_low_reg))
            begin
                clamped = 39'(range_low_reg);
            end
            if (clamped > 39'(range_high_reg))
            begin
                clamped = 39'(range_high_reg);
            end
        end
        if (clamped > 39'sh007FFFFFFF)
        begin
            new_est_next = 32'sh7FFFFFFF;
        end
        else if (clamped < -39'sh0080000000)
        begin
            new_est_next = 32'sh80000000;
        end
        else
        begin
            new_est_next = clamped[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_est_reg  <= new_est_next;
            residual_reg <= res_m_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_estimate = new_est_reg;
    assign residual     = residual_reg;

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[WGT_LAT] |-> (w_sel <= ONE_Q16))
        else $error("Relaxation weight exceeds one.");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(vld_m_reg) && $stable(vld_reg[WGT_LAT])))
        else $error("Pipeline moved while the output transaction was stalled.");

    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clamp_enable_reg && range_low_reg <= range_high_reg)
        |-> (new_est_reg >= range_low_reg && new_est_reg <= range_high_reg))
        else $error("Clamped estimate lies outside the range limits.");

endmodule
`default_nettype wire
